>>> rtl/payload_word_tokenizer_unit_defines.svh
// Assertion macros shared by the checker of the payload word tokenizer.
// Each macro expands to one labeled concurrent assertion on clk with rst_n.
`ifndef PAYLOAD_WORD_TOKENIZER_UNIT_DEFINES_SVH
`define PAYLOAD_WORD_TOKENIZER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define PWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> rtl/pwt_pkg.sv
// Shared types, constants and limits of the payload word tokenizer.
// Used by the decoder, the emitter, the top level and the checker.
package pwt_pkg;

    localparam int MAX_WORDS    = 16;
    localparam int MAX_WORD_LEN = 63;

    localparam int WPP_W      = 5;
    localparam int MWC_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int WC_W       = $clog2(MAX_WORDS + 2);
    localparam int CH_W       = $clog2(MAX_WORD_LEN + 1);
    localparam int SLOTS      = 3;
    localparam int SLOT_IDX_W = 2;

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] ESC_OFFSET = 8'd64;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOP  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORDS = 1'b0,
        REG_CHARS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_BYTE,
        PH_CLOSE,
        PH_PAD_DOT,
        PH_PAD_END,
        PH_EOP
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
    } res_t;

    typedef struct packed {
        logic [WC_W-1:0] words_done;
        logic [CH_W-1:0] chars;
        logic            open;
    } tok_state_t;

    typedef struct packed {
        res_t [SLOTS-1:0]      slot;
        logic [SLOT_IDX_W-1:0] n;
        logic                  fin;
        logic                  close;
        logic [WC_W-1:0]       pad;
    } plan_t;

endpackage

>>> rtl/pwt_decode.sv
// Combinational decoder: turns one input word and the tokenizer state into an
// emission plan and the next state. Depends on pwt_pkg.
module pwt_decode
(
    input  logic [7:0]                  payload_byte,
    input  logic                        has_byte,
    input  logic                        end_of_payload,
    input  logic [pwt_pkg::WPP_W-1:0]   words_per_payload,
    input  logic [pwt_pkg::MWC_W-1:0]   max_word_chars,
    input  pwt_pkg::tok_state_t         state,
    output pwt_pkg::tok_state_t         state_next,
    output pwt_pkg::plan_t              plan,
    output logic                        nonempty
);

    logic [pwt_pkg::WC_W-1:0]       lim_w;
    logic [pwt_pkg::CH_W-1:0]       lim_c;
    pwt_pkg::tok_state_t            s;
    pwt_pkg::res_t [pwt_pkg::SLOTS-1:0] slot;
    logic [pwt_pkg::SLOT_IDX_W-1:0] n;
    logic [7:0]                     c0;
    logic                           is_sep;
    logic                           is_esc;

    always_comb
    begin
        if (int'(words_per_payload) > pwt_pkg::MAX_WORDS)
        begin
            lim_w = pwt_pkg::WC_W'(pwt_pkg::MAX_WORDS);
        end
        else
        begin
            lim_w = pwt_pkg::WC_W'(words_per_payload);
        end
        if (int'(max_word_chars) > pwt_pkg::MAX_WORD_LEN)
        begin
            lim_c = pwt_pkg::CH_W'(pwt_pkg::MAX_WORD_LEN);
        end
        else
        begin
            lim_c = pwt_pkg::CH_W'(max_word_chars);
        end
    end

    assign is_sep = (payload_byte > pwt_pkg::CH_TILDE) || (payload_byte == pwt_pkg::CH_SPACE);
    assign is_esc = (payload_byte < pwt_pkg::CH_SPACE) || (payload_byte == pwt_pkg::CH_CARET);
    assign c0     = is_esc ? pwt_pkg::CH_CARET : payload_byte;

    always_comb
    begin
        s    = state;
        slot = '0;
        n    = '0;
        plan = '0;

        if (has_byte && (s.words_done < lim_w))
        begin
            if (is_sep)
            begin
                if (s.open)
                begin
                    slot[n] = '{kind: pwt_pkg::KIND_END, ch: 8'd0};
                    n = n + 1'b1;
                    if (s.words_done != '1)
                    begin
                        s.words_done = s.words_done + 1'b1;
                    end
                    s.open  = 1'b0;
                    s.chars = '0;
                end
            end
            else
            begin
                if (!s.open)
                begin
                    slot[n] = '{kind: pwt_pkg::KIND_CHAR, ch: pwt_pkg::CH_DOT};
                    n = n + 1'b1;
                    s.open  = 1'b1;
                    s.chars = '0;
                end
                if (s.chars < lim_c)
                begin
                    slot[n] = '{kind: pwt_pkg::KIND_CHAR, ch: c0};
                    n = n + 1'b1;
                    s.chars = s.chars + 1'b1;
                end
                if (payload_byte == pwt_pkg::CH_NL)
                begin
                    slot[n] = '{kind: pwt_pkg::KIND_END, ch: 8'd0};
                    n = n + 1'b1;
                    if (s.words_done != '1)
                    begin
                        s.words_done = s.words_done + 1'b1;
                    end
                    s.open  = 1'b0;
                    s.chars = '0;
                end
                else if (is_esc && (s.chars < lim_c))
                begin
                    slot[n] = '{kind: pwt_pkg::KIND_CHAR,
                                ch: payload_byte + pwt_pkg::ESC_OFFSET};
                    n = n + 1'b1;
                    s.chars = s.chars + 1'b1;
                end
            end
        end

        plan.slot = slot;
        plan.n    = n;

        if (end_of_payload)
        begin
            plan.fin   = 1'b1;
            plan.close = s.open;
            if (s.open && (s.words_done != '1))
            begin
                s.words_done = s.words_done + 1'b1;
            end
            if (s.words_done < lim_w)
            begin
                plan.pad = lim_w - s.words_done;
            end
            state_next = '0;
        end
        else
        begin
            state_next = s;
        end
    end

    assign nonempty = (n != '0) || end_of_payload;

endmodule

>>> rtl/pwt_emitter.sv
// Emission sequencer: holds one plan, steps through its results one per cycle
// while m_tready allows, and drives the registered output word. Uses pwt_pkg.
module pwt_emitter
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  pwt_pkg::plan_t plan_in,
    output logic           plan_free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_char
    output logic [1:0]     m_tuser,   // out_kind
    output logic           m_tlast
);

    logic                           busy_reg;
    logic                           busy_next;
    pwt_pkg::phase_t                phase_reg;
    pwt_pkg::phase_t                phase_next;
    logic [pwt_pkg::SLOT_IDX_W-1:0] idx_reg;
    logic [pwt_pkg::SLOT_IDX_W-1:0] idx_next;
    logic [pwt_pkg::WC_W-1:0]       pad_reg;
    logic [pwt_pkg::WC_W-1:0]       pad_next;
    pwt_pkg::plan_t                 plan_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    pwt_pkg::res_t                  out_res_reg;
    logic                           out_last_reg;

    pwt_pkg::res_t                  cur;
    logic                           cur_last;
    logic                           advance;
    pwt_pkg::phase_t                after_bytes;
    pwt_pkg::phase_t                start_phase;

    assign advance   = busy_reg && (!out_valid_reg || m_tready);
    assign plan_free = !busy_reg || (advance && cur_last);

    always_comb
    begin
        if (plan_reg.close)
        begin
            after_bytes = pwt_pkg::PH_CLOSE;
        end
        else if (plan_reg.pad != '0)
        begin
            after_bytes = pwt_pkg::PH_PAD_DOT;
        end
        else
        begin
            after_bytes = pwt_pkg::PH_EOP;
        end

        if (plan_in.n != '0)
        begin
            start_phase = pwt_pkg::PH_BYTE;
        end
        else if (plan_in.close)
        begin
            start_phase = pwt_pkg::PH_CLOSE;
        end
        else if (plan_in.pad != '0)
        begin
            start_phase = pwt_pkg::PH_PAD_DOT;
        end
        else
        begin
            start_phase = pwt_pkg::PH_EOP;
        end
    end

    always_comb
    begin
        cur        = '{kind: pwt_pkg::KIND_EOP, ch: 8'd0};
        cur_last   = 1'b0;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        busy_next  = busy_reg;

        case (phase_reg)
            pwt_pkg::PH_BYTE:
            begin
                cur = plan_reg.slot[idx_reg];
                if (idx_reg == plan_reg.n - 1'b1)
                begin
                    cur_last   = !plan_reg.fin;
                    phase_next = after_bytes;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pwt_pkg::PH_CLOSE:
            begin
                cur = '{kind: pwt_pkg::KIND_END, ch: 8'd0};
                if (pad_reg != '0)
                begin
                    phase_next = pwt_pkg::PH_PAD_DOT;
                end
                else
                begin
                    phase_next = pwt_pkg::PH_EOP;
                end
            end
            pwt_pkg::PH_PAD_DOT:
            begin
                cur        = '{kind: pwt_pkg::KIND_CHAR, ch: pwt_pkg::CH_DOT};
                phase_next = pwt_pkg::PH_PAD_END;
            end
            pwt_pkg::PH_PAD_END:
            begin
                cur      = '{kind: pwt_pkg::KIND_END, ch: 8'd0};
                pad_next = pad_reg - 1'b1;
                if (pad_reg == pwt_pkg::WC_W'(1))
                begin
                    phase_next = pwt_pkg::PH_EOP;
                end
                else
                begin
                    phase_next = pwt_pkg::PH_PAD_DOT;
                end
            end
            pwt_pkg::PH_EOP:
            begin
                cur      = '{kind: pwt_pkg::KIND_EOP, ch: 8'd0};
                cur_last = 1'b1;
            end
            default:
            begin
                cur_last = 1'b1;
            end
        endcase

        if (!advance)
        begin
            phase_next = phase_reg;
            idx_next   = idx_reg;
            pad_next   = pad_reg;
        end
        else if (cur_last)
        begin
            busy_next = 1'b0;
        end

        if (load)
        begin
            busy_next  = 1'b1;
            phase_next = start_phase;
            idx_next   = '0;
            pad_next   = plan_in.pad;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= pwt_pkg::PH_EOP;
            idx_reg       <= '0;
            pad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            pad_reg       <= pad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan_in;
        end
        if (advance)
        begin
            out_res_reg  <= cur;
            out_last_reg <= cur_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.ch;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/payload_word_tokenizer_unit.sv
// Payload word tokenizer top level; uses pwt_pkg, pwt_decode and pwt_emitter.
// The plan of an accepted input word is registered in the emitter; each result is then registered at the output.
// Throughput: one result per cycle while m_tready does not stall the output; an input
// word is held until the single emission sequencer is free to take its plan.
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the word
// state and sets words_per_payload to 8 and max_word_chars to 16.
module payload_word_tokenizer_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // payload_byte
    input  logic                           s_tuser,   // has_byte
    input  logic                           s_tlast,   // end_of_payload
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // out_char
    output logic [1:0]                     m_tuser,   // out_kind
    output logic                           m_tlast    // run_last
);

    logic [pwt_pkg::WPP_W-1:0] wpp_reg;
    logic [pwt_pkg::MWC_W-1:0] mwc_reg;
    pwt_pkg::tok_state_t       state_reg;
    pwt_pkg::tok_state_t       state_next;
    pwt_pkg::plan_t            plan;
    logic                      nonempty;
    logic                      plan_free;
    logic                      accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = plan_free;
    assign accept    = s_tvalid && plan_free;

    pwt_decode u_decode
    (
        .payload_byte      (s_tdata),
        .has_byte          (s_tuser),
        .end_of_payload    (s_tlast),
        .words_per_payload (wpp_reg),
        .max_word_chars    (mwc_reg),
        .state             (state_reg),
        .state_next        (state_next),
        .plan              (plan),
        .nonempty          (nonempty)
    );

    pwt_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && nonempty),
        .plan_in   (plan),
        .plan_free (plan_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpp_reg   <= pwt_pkg::WPP_W'(8);
            mwc_reg   <= pwt_pkg::MWC_W'(16);
            state_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (pwt_pkg::cfg_reg_t'(cfg_index))
                    pwt_pkg::REG_WORDS: wpp_reg <= cfg_data[pwt_pkg::WPP_W-1:0];
                    pwt_pkg::REG_CHARS: mwc_reg <= cfg_data[pwt_pkg::MWC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

endmodule

>>> rtl/pwt_checker.sv
// Port-level checker for the payload word tokenizer, bound to the top level.
// Depends on pwt_pkg and the assertion macros header.
`include "payload_word_tokenizer_unit_defines.svh"

module pwt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    `PWT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `PWT_ASSERT_SAME(a_marker_zero, m_tvalid && (m_tuser != pwt_pkg::KIND_CHAR), m_tdata == 8'd0)
    `PWT_ASSERT_SAME(a_eop_last, m_tvalid && (m_tuser == pwt_pkg::KIND_EOP), m_tlast)
    `PWT_ASSERT_SAME(a_kind_code, m_tvalid, (m_tuser == pwt_pkg::KIND_CHAR) || (m_tuser == pwt_pkg::KIND_END) || (m_tuser == pwt_pkg::KIND_EOP))

endmodule

bind payload_word_tokenizer_unit pwt_checker u_pwt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> sim/tb_payload_word_tokenizer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for payload_word_tokenizer_unit: directed table, then random payloads.
// Expected words: table rows or a tokenizer model here; depends on pwt_pkg and the RTL only.
module tb_payload_word_tokenizer_unit;

    localparam int ITEMS      = 470;
    localparam int RESULT_CAP = 40;
    localparam int DRAIN      = 12;
    localparam int LIMIT      = 600000;
    localparam int IDLE_PCT   = 23;

    localparam pwt_pkg::kind_t    K_CHR = pwt_pkg::KIND_CHAR;
    localparam pwt_pkg::kind_t    K_END = pwt_pkg::KIND_END;
    localparam pwt_pkg::kind_t    K_EOP = pwt_pkg::KIND_EOP;
    localparam pwt_pkg::cfg_reg_t R_WPP = pwt_pkg::REG_WORDS;
    localparam pwt_pkg::cfg_reg_t R_MWC = pwt_pkg::REG_CHARS;
    localparam logic [7:0]        DOT   = pwt_pkg::CH_DOT;
    localparam logic [7:0]        CARET = pwt_pkg::CH_CARET;
    localparam logic [7:0]        TILDE = pwt_pkg::CH_TILDE;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;

    typedef struct {
        pwt_pkg::kind_t kind;
        logic [7:0]     ch;
        logic           last;
    } tok_word_t;

    typedef struct {
        row_op_t           op;
        pwt_pkg::cfg_reg_t idx;
        logic [7:0]        val;
        logic              has;
        logic              eop;
        int                ntyp;
        pwt_pkg::kind_t    k0;
        logic [7:0]        c0;
        pwt_pkg::kind_t    k1;
        logic [7:0]        c1;
    } plan_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pwt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pwt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;

    tok_word_t  expected_words[$];
    tok_word_t  step_words[$];
    plan_row_t  plan_rows[$];
    tok_word_t  head_word;

    logic [4:0] cfg_words = 5'd8;
    logic [5:0] cfg_chars = 6'd16;
    int         tk_words_done = 0;
    int         tk_chars = 0;
    bit         tk_open = 1'b0;

    int         errors = 0;
    int         items_sent = 0;
    int         cycles = 0;
    bit         no_idle = 1'b0;
    bit         paused = 1'b0;

    payload_word_tokenizer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int word_limit();
        return (cfg_words > pwt_pkg::MAX_WORDS) ? pwt_pkg::MAX_WORDS : int'(cfg_words);
    endfunction

    function automatic void emit(pwt_pkg::kind_t k, logic [7:0] c);
        if (step_words.size() < RESULT_CAP)
            step_words.push_back('{kind: k, ch: c, last: 1'b0});
    endfunction

    function automatic void add_char(logic [7:0] c);
        int lim;
        lim = (cfg_chars > pwt_pkg::MAX_WORD_LEN) ? pwt_pkg::MAX_WORD_LEN : int'(cfg_chars);
        if (!tk_open)
        begin
            emit(pwt_pkg::KIND_CHAR, pwt_pkg::CH_DOT);
            tk_open = 1'b1;
            tk_chars = 0;
        end
        if (tk_chars < lim)
        begin
            emit(pwt_pkg::KIND_CHAR, c);
            tk_chars++;
        end
    endfunction

    function automatic void close_word();
        emit(pwt_pkg::KIND_END, 8'h00);
        if (tk_words_done < 31)
            tk_words_done++;
        tk_open = 1'b0;
        tk_chars = 0;
    endfunction

    function automatic void tokenize_item(logic [7:0] b, logic has, logic eop);
        step_words.delete();
        if (has && tk_words_done < word_limit())
        begin
            if (b > pwt_pkg::CH_TILDE || b == pwt_pkg::CH_SPACE)
            begin
                if (tk_open)
                    close_word();
            end
            else if (b == pwt_pkg::CH_NL)
            begin
                add_char(pwt_pkg::CH_CARET);
                close_word();
            end
            else if (b < pwt_pkg::CH_SPACE || b == pwt_pkg::CH_CARET)
            begin
                add_char(pwt_pkg::CH_CARET);
                add_char(b + pwt_pkg::ESC_OFFSET);
            end
            else
                add_char(b);
        end
        if (eop)
        begin
            if (tk_open)
                close_word();
            while (tk_words_done < word_limit())
            begin
                emit(pwt_pkg::KIND_CHAR, pwt_pkg::CH_DOT);
                close_word();
            end
            emit(pwt_pkg::KIND_EOP, 8'h00);
            tk_words_done = 0;
            tk_chars = 0;
            tk_open = 1'b0;
        end
        if (step_words.size() > 0)
            step_words[$].last = 1'b1;
    endfunction

    task automatic note_mismatch(input string what);
        errors++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input pwt_pkg::cfg_reg_t idx, input logic [5:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == pwt_pkg::REG_WORDS)
            cfg_words = data[4:0];
        else
            cfg_chars = data;
    endtask

    task automatic send_item(input plan_row_t r);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.val;
        s_tuser  <= r.has;
        s_tlast  <= r.eop;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (r.has || r.eop)
            items_sent++;
        tokenize_item(r.val, r.has, r.eop);
        if (r.ntyp < 0)
        begin
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
        end
        else
        begin
            if (r.ntyp > 0)
                expected_words.push_back('{kind: r.k0, ch: r.c0, last: (r.ntyp == 1)});
            if (r.ntyp > 1)
                expected_words.push_back('{kind: r.k1, ch: r.c1, last: 1'b1});
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic has, input logic eop);
        plan_row_t r;
        if ($urandom_range(0, 99) < 3)
        begin
            r = '{ROW_ITEM, R_WPP, 8'($urandom), 1'b0, 1'b0, -1, K_CHR, 8'h00, K_CHR, 8'h00};
            send_item(r);
        end
        r = '{ROW_ITEM, R_WPP, b, has, eop, -1, K_CHR, 8'h00, K_CHR, 8'h00};
        send_item(r);
        no_idle = (items_sent >= 150 && items_sent < 260);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78)
            return 8'($urandom_range(8'h21, 8'h7E));
        else if (r < 90)
            return 8'($urandom_range(0, 31));
        else if (r < 95)
            return pwt_pkg::CH_CARET;
        else
            return 8'($urandom_range(8'h7F, 8'hFF));
    endfunction

    function automatic logic [7:0] word_sep();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return pwt_pkg::CH_SPACE;
        else if (r < 75)
            return pwt_pkg::CH_NL;
        else
            return 8'($urandom_range(8'h7F, 8'hFF));
    endfunction

    task automatic send_payload();
        int  n_words;
        int  len;
        bit  noisy;
        noisy = ($urandom_range(0, 9) == 0);
        n_words = $urandom_range(0, 8);
        for (int w = 0; w < n_words; w++)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 10);
            for (int k = 0; k < len; k++)
                send_byte(noisy ? 8'($urandom) : word_char(), noisy ? 1'($urandom) : 1'b1, 1'b0);
            send_byte(word_sep(), 1'b1, 1'b0);
        end
        send_byte(8'($urandom), 1'($urandom), 1'b1);
    endtask

    function automatic logic [5:0] pick_words();
        case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd16;
            3: return 6'h3F;
            default: return 6'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] pick_chars();
        case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd63;
            default: return 6'($urandom_range(0, 8));
        endcase
    endfunction

    always @(posedge clk)
    begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
                note_mismatch($sformatf("unexpected word kind %0d char %02h last %0b",
                                        m_tuser, m_tdata, m_tlast));
            else
            begin
                head_word = expected_words.pop_front();
                if (m_tuser !== head_word.kind || m_tdata !== head_word.ch
                    || m_tlast !== head_word.last)
                    note_mismatch($sformatf("got kind %0d char %02h last %0b, want %0d %02h %0b",
                                            m_tuser, m_tdata, m_tlast, head_word.kind,
                                            head_word.ch, head_word.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("tb_payload_word_tokenizer_unit: errors");
            $finish;
        end
    end

    initial
    begin
        // Right after reset: eight words of sixteen characters.
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h41, 1'b1, 1'b0, 2, K_CHR, DOT, K_CHR, 8'h41});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h5E, 1'b1, 1'b0, 2, K_CHR, CARET, K_CHR, 8'h9E});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h00, 1'b1, 1'b0, 2, K_CHR, CARET, K_CHR, 8'h40});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h1F, 1'b1, 1'b0, 2, K_CHR, CARET, K_CHR, 8'h5F});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h7E, 1'b1, 1'b0, 1, K_CHR, TILDE, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h20, 1'b1, 1'b0, 1, K_END, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h20, 1'b1, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'hFF, 1'b1, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h0A, 1'b1, 1'b0, -1, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'hAA, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h78, 1'b1, 1'b0, -1, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h79, 1'b1, 1'b1, -1, K_CHR, 8'h00, K_CHR, 8'h00});
        // No words at all: bytes are dropped and the end marker stands alone.
        plan_rows.push_back('{ROW_CFG, R_WPP, 8'h00, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_CFG, R_MWC, 8'h00, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h41, 1'b1, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h00, 1'b0, 1'b1, 1, K_EOP, 8'h00, K_CHR, 8'h00});
        // Zero characters per word: only the dot survives.
        plan_rows.push_back('{ROW_CFG, R_WPP, 8'h02, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h42, 1'b1, 1'b0, 1, K_CHR, DOT, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h01, 1'b1, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h80, 1'b1, 1'b1, -1, K_CHR, 8'h00, K_CHR, 8'h00});
        // Word count above the maximum saturates; one character cuts an escape in half.
        plan_rows.push_back('{ROW_CFG, R_WPP, 8'h3F, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_CFG, R_MWC, 8'h01, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h1B, 1'b1, 1'b0, 2, K_CHR, DOT, K_CHR, CARET});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h55, 1'b0, 1'b1, -1, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_CFG, R_WPP, 8'h01, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_CFG, R_MWC, 8'h3F, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h61, 1'b1, 1'b0, 2, K_CHR, DOT, K_CHR, 8'h61});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h20, 1'b1, 1'b0, 1, K_END, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h62, 1'b1, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h0D, 1'b0, 1'b1, -1, K_CHR, 8'h00, K_CHR, 8'h00});
        // The word limit drops below the open word, which must still be closed.
        plan_rows.push_back('{ROW_CFG, R_WPP, 8'h02, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h70, 1'b1, 1'b0, 2, K_CHR, DOT, K_CHR, 8'h70});
        plan_rows.push_back('{ROW_CFG, R_WPP, 8'h00, 1'b0, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h71, 1'b1, 1'b0, 0, K_CHR, 8'h00, K_CHR, 8'h00});
        plan_rows.push_back('{ROW_ITEM, R_WPP, 8'h00, 1'b0, 1'b1, -1, K_CHR, 8'h00, K_CHR, 8'h00});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i])
        begin
            if (plan_rows[i].op == ROW_CFG)
            begin
                wait_drained();
                write_reg(plan_rows[i].idx, plan_rows[i].val[5:0]);
            end
            else
                send_item(plan_rows[i]);
        end

        while (items_sent < ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
                write_reg(pwt_pkg::REG_WORDS, pick_words());
                wait_drained();
                write_reg(pwt_pkg::REG_CHARS, pick_chars());
            end
            if (!paused && items_sent >= 350)
            begin
                wait_drained();
                paused = 1'b1;
            end
            send_payload();
        end

        wait_drained();
        if (errors == 0)
            $display("tb_payload_word_tokenizer_unit: clean");
        else
            $display("tb_payload_word_tokenizer_unit: errors");
        $finish;
    end

endmodule
